>>> hdl/hspr_pkg.sv
// Package with shared types, phase codes and bit-step functions for the SPS resolution parser.
package hspr_pkg;

  // Input item: one byte of the NAL unit and the end-of-unit flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hspr_in_t;

  // Result item: decoded picture size and the truncation flag.
  typedef struct packed {
    logic [15:0] pic_width;
    logic [15:0] pic_height;
    logic        truncated;
  } hspr_out_t;

  // Parse phase codes.
  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_VPS_ID = 4'd1;
  localparam logic [3:0] PH_SUBLAY = 4'd2;
  localparam logic [3:0] PH_PTL    = 4'd3;
  localparam logic [3:0] PH_SPS_ID = 4'd4;
  localparam logic [3:0] PH_CHROMA = 4'd5;
  localparam logic [3:0] PH_PLANE  = 4'd6;
  localparam logic [3:0] PH_WIDTH  = 4'd7;
  localparam logic [3:0] PH_HEIGHT = 4'd8;
  localparam logic [3:0] PH_DONE   = 4'd9;
  localparam logic [3:0] PH_OTHER  = 4'd15;

  // Header and syntax constants.
  localparam logic [5:0]  SPS_TYPE       = 6'd33;
  localparam logic [6:0]  PTL_BITS       = 7'd97;
  localparam logic [6:0]  SUBLAYER_EXTRA = 7'd16;
  localparam logic [6:0]  VPS_ID_BITS    = 7'd4;
  localparam logic [6:0]  SUBLAY_BITS    = 7'd3;
  localparam logic [7:0]  EPB_BYTE       = 8'h03;
  localparam logic [32:0] GV_MAX         = 33'h1_FFFF_FFFF;
  localparam logic [32:0] CHROMA_444     = 33'd4;
  localparam logic [5:0]  LZ_MAX         = 6'd63;

  // Bit-level parser state for the SPS payload.
  typedef struct packed {
    logic [3:0]  phase;
    logic [6:0]  bits_left;
    logic [5:0]  lead_zeros;
    logic [32:0] golomb;
    logic [2:0]  sub_layer;
    logic        multi_layer;
    logic [15:0] width;
    logic [15:0] height;
  } hspr_parse_t;

  // Code minus one, saturated to 16 bits.
  function automatic logic [15:0] sat16(logic [32:0] code);
    logic [32:0] v;
    v = code - 33'd1;
    if (|v[32:16]) begin
      return 16'hFFFF;
    end
    return v[15:0];
  endfunction

  // Close an Exp-Golomb code and move to the next syntax element.
  function automatic hspr_parse_t finish_golomb(hspr_parse_t s);
    hspr_parse_t r;
    r = s;
    case (s.phase)
      PH_SPS_ID: r.phase = PH_CHROMA;
      PH_CHROMA: r.phase = (s.golomb == CHROMA_444) ? PH_PLANE : PH_WIDTH;
      PH_WIDTH: begin
        r.width = sat16(s.golomb);
        r.phase = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        r.height = sat16(s.golomb);
        r.phase  = PH_DONE;
      end
      default: ;
    endcase
    r.golomb     = '0;
    r.lead_zeros = '0;
    r.bits_left  = '0;
    return r;
  endfunction

  // One bit of an Exp-Golomb code: prefix zeros, then the suffix bits.
  function automatic hspr_parse_t golomb_bit(hspr_parse_t s, logic b);
    hspr_parse_t r;
    r = s;
    if (s.golomb == '0) begin
      if (!b) begin
        if (s.lead_zeros != LZ_MAX) r.lead_zeros = s.lead_zeros + 6'd1;
      end else begin
        r.golomb    = 33'd1;
        r.bits_left = {1'b0, s.lead_zeros};
        if (s.lead_zeros == '0) r = finish_golomb(r);
      end
    end else begin
      if (s.golomb[32]) begin
        r.golomb = GV_MAX;
      end else begin
        r.golomb = {s.golomb[31:0], b};
      end
      r.bits_left = s.bits_left - 7'd1;
      if (r.bits_left == '0) r = finish_golomb(r);
    end
    return r;
  endfunction

  // One payload bit through the SPS syntax.
  function automatic hspr_parse_t take_bit(hspr_parse_t s, logic b);
    hspr_parse_t r;
    r = s;
    case (s.phase)
      PH_VPS_ID: begin
        r.bits_left = s.bits_left - 7'd1;
        if (r.bits_left == '0) begin
          r.phase     = PH_SUBLAY;
          r.bits_left = SUBLAY_BITS;
          r.sub_layer = '0;
        end
      end
      PH_SUBLAY: begin
        r.sub_layer = {s.sub_layer[1:0], b};
        r.bits_left = s.bits_left - 7'd1;
        if (r.bits_left == '0) begin
          if (s.multi_layer) begin
            r.phase = PH_SPS_ID;
          end else begin
            r.phase     = PH_PTL;
            r.bits_left = PTL_BITS + ((r.sub_layer != '0) ? SUBLAYER_EXTRA : 7'd0);
          end
        end
      end
      PH_PTL: begin
        r.bits_left = s.bits_left - 7'd1;
        if (r.bits_left == '0) r.phase = PH_SPS_ID;
      end
      PH_SPS_ID, PH_CHROMA, PH_WIDTH, PH_HEIGHT: r = golomb_bit(s, b);
      PH_PLANE: r.phase = PH_WIDTH;
      default: ;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/hspr_byte_parse.sv
// Eight chained bit steps that advance the SPS parser state by one payload byte.
module hspr_byte_parse (
  input  hspr_pkg::hspr_parse_t state_i,
  input  logic [7:0]            byte_i,
  output hspr_pkg::hspr_parse_t state_o
);

  hspr_pkg::hspr_parse_t chain [9];

  // MSB first, one bit step per stage of the chain.
  always_comb begin
    chain[0] = state_i;
    for (int k = 0; k < 8; k++) begin
      chain[k + 1] = hspr_pkg::take_bit(chain[k], byte_i[7 - k]);
    end
  end

  assign state_o = chain[8];

endmodule

>>> hdl/hevc_sps_resolution_parser.sv
// Top level of the H.265 SPS resolution parser: input stage, byte step and result register.
//
//  Channel | Handshake                     | Payload
//  --------+-------------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o       | in_data_i  (data_byte, last_byte)
//  out     | out_valid_o / out_ready_i     | out_data_o (pic_width, pic_height, truncated)
//
// One byte is taken every cycle unless a waiting result stalls the input. An accepted
// item sits in the input register and is parsed there in a single pass (eight unrolled
// bit steps) once the result side can take it. Its result, if any, lands in the result
// register, which drives out_valid_o. Reset clears the parser to wait for a NAL header.
// While a result waits in the result register no byte is parsed, whether it yields a result
// or not; the input register still takes one more item, and then in_ready_o stays low.
module hevc_sps_resolution_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hspr_pkg::hspr_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hspr_pkg::hspr_out_t out_data_o
);

  // Input stage.
  logic                 in_valid_q, in_valid_d;
  hspr_pkg::hspr_in_t   in_q;
  // Result stage.
  logic                 out_valid_q, out_valid_d;
  hspr_pkg::hspr_out_t  out_q, out_d;
  // Unit-level state.
  logic [15:0]          header_q, header_d;
  logic [1:0]           byte_idx_q, byte_idx_d;
  logic [1:0]           zero_run_q, zero_run_d;
  hspr_pkg::hspr_parse_t parse_q, parse_d, parse_byte;

  logic        fire;
  logic        drop;
  logic        emit;
  logic [15:0] header_new;
  logic [7:0]  b;

  assign b    = in_q.data_byte;
  assign fire = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  hspr_byte_parse u_byte_parse (
    .state_i (parse_q),
    .byte_i  (b),
    .state_o (parse_byte)
  );

  // Byte-level processing: emulation prevention, header, payload and unit end.
  always_comb begin
    header_d   = header_q;
    byte_idx_d = byte_idx_q;
    zero_run_d = zero_run_q;
    parse_d    = parse_q;
    header_new = {header_q[7:0], b};
    drop       = (zero_run_q >= 2'd2) && (b == hspr_pkg::EPB_BYTE);
    emit       = 1'b0;
    out_d      = out_q;

    if (drop) begin
      zero_run_d = '0;
    end else begin
      if (b == 8'd0) begin
        if (zero_run_q < 2'd2) zero_run_d = zero_run_q + 2'd1;
      end else begin
        zero_run_d = '0;
      end

      if (byte_idx_q < 2'd2) begin
        header_d   = header_new;
        byte_idx_d = byte_idx_q + 2'd1;
        if (byte_idx_d == 2'd2) begin
          if (header_new[14:9] == hspr_pkg::SPS_TYPE) begin
            parse_d.phase       = hspr_pkg::PH_VPS_ID;
            parse_d.bits_left   = hspr_pkg::VPS_ID_BITS;
            parse_d.multi_layer = (header_new[8:3] != 6'd0);
          end else begin
            parse_d.phase = hspr_pkg::PH_OTHER;
          end
        end
      end else if (parse_q.phase >= hspr_pkg::PH_VPS_ID &&
                   parse_q.phase <= hspr_pkg::PH_HEIGHT) begin
        parse_d = parse_byte;
      end
    end

    // End of unit: report an SPS and return to the header wait.
    if (in_q.last_byte) begin
      if (parse_d.phase >= hspr_pkg::PH_VPS_ID && parse_d.phase <= hspr_pkg::PH_DONE) begin
        emit             = 1'b1;
        out_d.pic_width  = parse_d.width;
        out_d.pic_height = parse_d.height;
        out_d.truncated  = (parse_d.phase != hspr_pkg::PH_DONE);
      end
      header_d   = '0;
      byte_idx_d = '0;
      zero_run_d = '0;
      parse_d    = '0;
    end
  end

  // Handshake control for both stages.
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      header_q    <= '0;
      byte_idx_q  <= '0;
      zero_run_q  <= '0;
      parse_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        header_q   <= header_d;
        byte_idx_q <= byte_idx_d;
        zero_run_q <= zero_run_d;
        parse_q    <= parse_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (fire && emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A processed last byte leaves the parser waiting for a fresh header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_q.last_byte |=> byte_idx_q == 2'd0 && parse_q.phase == hspr_pkg::PH_HEADER)
    else $error("parser state not cleared after end of unit");

  // Parsing starts only after both header bytes were taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_q.phase != hspr_pkg::PH_HEADER |-> byte_idx_q == 2'd2)
    else $error("parse phase left header wait before header was complete");

  // A held input item is neither lost nor changed while the result side stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_q))
    else $error("stalled input item was overwritten");

endmodule
